### rtl/core/lav_pkg.sv
`default_nettype none
package lav_pkg;
  localparam int unsigned MagW = 30;
  localparam int unsigned SumW = 2 * MagW + 2;
  localparam int unsigned LenW = MagW + 1;
  localparam int unsigned QuoW = 15;
  localparam int unsigned ResW = 16;
  localparam logic [QuoW-1:0] QuoOne = 15'd16384;
  typedef logic signed [ResW-1:0] res_t;
endpackage
`default_nettype wire

### rtl/core/lav_norm.sv
`default_nettype none
module lav_norm import lav_pkg::*; #(
  parameter int unsigned IW = 33,
  parameter int unsigned SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [3*IW-1:0]   vec_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [3*ResW-1:0] res_o,
  output logic [SW-1:0]     side_o
);
  localparam int unsigned TW = $clog2(IW);
  localparam int unsigned XW = IW + MagW;
  localparam int unsigned RemW = MagW + QuoW + 1;
  localparam int unsigned TopT = MagW - 1;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
    logic [SW-1:0]        side;
  } nrm_t;

  // abs
  logic               va_q;
  logic [2:0][IW-1:0] maga_q, maga_d;
  logic [2:0]         nega_q, nega_d;
  logic [SW-1:0]      sidea_q;

  always_comb begin
    logic [IW-1:0] comp;
    for (int i = 0; i < 3; i++) begin
      comp = vec_i[i*IW +: IW];
      nega_d[i] = comp[IW-1];
      maga_d[i] = comp[IW-1] ? (~comp + IW'(1)) : comp;
    end
  end

  // max
  logic               vb_q;
  logic [IW-1:0]      m_q, m_d;
  logic [2:0][IW-1:0] magb_q;
  logic [2:0]         negb_q;
  logic [SW-1:0]      sideb_q;

  always_comb begin
    logic [IW-1:0] m01;
    m01 = (maga_q[0] > maga_q[1]) ? maga_q[0] : maga_q[1];
    m_d = (m01 > maga_q[2]) ? m01 : maga_q[2];
  end

  // leading one
  logic               vc_q;
  logic [TW-1:0]      top_q, top_d;
  logic               zeroc_q;
  logic [2:0][IW-1:0] magc_q;
  logic [2:0]         negc_q;
  logic [SW-1:0]      sidec_q;

  always_comb begin
    top_d = '0;
    for (int k = 0; k < IW; k++) begin
      if (m_q[k]) top_d = TW'(k);
    end
  end

  // common shift
  logic vd_q, ve_q;
  nrm_t cd_q, cd_d, ce_q;
  logic [2:0][2*MagW-1:0] sq_q;

  always_comb begin
    logic [XW-1:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = XW'(magc_q[i]);
      if (top_q >= TW'(TopT)) wide = wide >> (top_q - TW'(TopT));
      else wide = wide << (TW'(TopT) - top_q);
      cd_d.mag[i] = wide[MagW-1:0];
    end
    cd_d.neg = negc_q;
    cd_d.zero = zeroc_q;
    cd_d.side = sidec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      maga_q  <= maga_d;
      nega_q  <= nega_d;
      sidea_q <= side_i;
      m_q     <= m_d;
      magb_q  <= maga_q;
      negb_q  <= nega_q;
      sideb_q <= sidea_q;
      top_q   <= top_d;
      zeroc_q <= (m_q == '0);
      magc_q  <= magb_q;
      negc_q  <= negb_q;
      sidec_q <= sideb_q;
      cd_q    <= cd_d;
      ce_q    <= cd_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= cd_q.mag[i] * cd_q.mag[i];
      end
    end
  end

  // square root, one root bit per stage
  logic            vs_q   [LenW+1];
  nrm_t            cs_q   [LenW+1];
  logic [SumW-1:0] rem_q  [LenW+1];
  logic [LenW-1:0] root_q [LenW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q[0] <= 1'b0;
    else if (en_i) vs_q[0] <= ve_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      root_q[0] <= '0;
      cs_q[0]   <= ce_q;
    end
  end

  for (genvar g = 0; g < LenW; g++) begin : g_sqrt
    localparam int unsigned Bit = LenW - 1 - g;
    logic [63:0]     test;
    logic [SumW-1:0] rem_d;
    logic [LenW-1:0] root_d;

    always_comb begin
      test = (64'(root_q[g]) << (Bit + 1)) + (64'd1 << (2 * Bit));
      rem_d = rem_q[g];
      root_d = root_q[g];
      if (64'(rem_q[g]) >= test) begin
        rem_d = rem_q[g] - test[SumW-1:0];
        root_d = root_q[g] | (LenW'(1) << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q[g+1] <= 1'b0;
      else if (en_i) vs_q[g+1] <= vs_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= rem_d;
        root_q[g+1] <= root_d;
        cs_q[g+1]   <= cs_q[g];
      end
    end
  end

  // division, one quotient bit per stage
  logic                 vq_q   [QuoW+1];
  nrm_t                 cq_q   [QuoW+1];
  logic [LenW-1:0]      len_q  [QuoW+1];
  logic [2:0][RemW-1:0] drem_q [QuoW+1];
  logic [2:0][QuoW-1:0] quo_q  [QuoW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq_q[0] <= 1'b0;
    else if (en_i) vq_q[0] <= vs_q[LenW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= RemW'({cs_q[LenW].mag[i], {(QuoW-1){1'b0}}})
                      + RemW'(root_q[LenW] >> 1);
        quo_q[0][i] <= '0;
      end
      len_q[0] <= root_q[LenW];
      cq_q[0]  <= cs_q[LenW];
    end
  end

  for (genvar g = 0; g < QuoW; g++) begin : g_div
    localparam int unsigned Bit = QuoW - 1 - g;
    logic [RemW-1:0]      dsr;
    logic [2:0][RemW-1:0] drem_d;
    logic [2:0][QuoW-1:0] quo_d;

    always_comb begin
      dsr = RemW'(len_q[g]) << Bit;
      for (int i = 0; i < 3; i++) begin
        drem_d[i] = drem_q[g][i];
        quo_d[i] = quo_q[g][i];
        if (drem_q[g][i] >= dsr) begin
          drem_d[i] = drem_q[g][i] - dsr;
          quo_d[i] = quo_q[g][i] | (QuoW'(1) << Bit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vq_q[g+1] <= 1'b0;
      else if (en_i) vq_q[g+1] <= vq_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[g+1] <= drem_d;
        quo_q[g+1]  <= quo_d;
        len_q[g+1]  <= len_q[g];
        cq_q[g+1]   <= cq_q[g];
      end
    end
  end

  // sign and zero vector
  logic            vo_q;
  res_t [2:0]      res_q, res_d;
  logic [SW-1:0]   sideo_q;

  always_comb begin
    logic [QuoW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (quo_q[QuoW][i] > QuoOne) ? QuoOne : quo_q[QuoW][i];
      if (cq_q[QuoW].zero) res_d[i] = '0;
      else if (cq_q[QuoW].neg[i]) res_d[i] = -res_t'({1'b0, q});
      else res_d[i] = res_t'({1'b0, q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= vq_q[QuoW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_d;
      sideo_q <= cq_q[QuoW].side;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;
  assign side_o  = sideo_q;
endmodule
`default_nettype wire

### rtl/core/lav_cross.sv
`default_nettype none
module lav_cross import lav_pkg::*; #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = ResW,
  parameter int unsigned SW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [3*AW-1:0]           a_i,
  input  logic [3*BW-1:0]           b_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [3*(AW+BW+1)-1:0]    c_o,
  output logic [SW-1:0]             side_o
);
  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = PW + 1;

  logic signed [AW-1:0] a0, a1, a2;
  logic signed [BW-1:0] b0, b1, b2;
  logic signed [PW-1:0] p_q [6];
  logic                 vp_q, vc_q;
  logic [SW-1:0]        sidep_q, sidec_q;
  logic [2:0][CW-1:0]   c_q;

  assign a0 = a_i[0 +: AW];
  assign a1 = a_i[AW +: AW];
  assign a2 = a_i[2*AW +: AW];
  assign b0 = b_i[0 +: BW];
  assign b1 = b_i[BW +: BW];
  assign b2 = b_i[2*BW +: BW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
      vc_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= a1 * b2;
      p_q[1]  <= a2 * b1;
      p_q[2]  <= a2 * b0;
      p_q[3]  <= a0 * b2;
      p_q[4]  <= a0 * b1;
      p_q[5]  <= a1 * b0;
      sidep_q <= side_i;
      c_q[0]  <= CW'(p_q[0]) - CW'(p_q[1]);
      c_q[1]  <= CW'(p_q[2]) - CW'(p_q[3]);
      c_q[2]  <= CW'(p_q[4]) - CW'(p_q[5]);
      sidec_q <= sidep_q;
    end
  end

  assign valid_o = vc_q;
  assign c_o     = c_q;
  assign side_o  = sidec_q;
endmodule
`default_nettype wire

### rtl/core/look_at_view_matrix_top.sv
// Look-at view matrix: one beat in carries eye, target and up (Q16.16), one beat out carries
// the side, recomputed up and back rows in Q1.14 and the saturated negated eye. A new beat
// is taken every cycle while the output is not stalled; the pipeline holds three chained
// normalizers, each with a 31-stage bit-per-stage square root and a 15-stage divider. A
// stalled output only holds the pipeline once a finished result sits behind the output beat.
`default_nettype none
module look_at_view_matrix_top import lav_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [287:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // side_x/y/z, upright_x/y/z, back_x/y/z (16 bits each), shift_x/y/z (32 bits each)
  output logic [239:0] m_axis_tdata_o
);
  logic        en;
  logic        v0_q;
  logic [98:0] d_q;
  logic [191:0] side0_q;

  logic         v1, v2, v3, v4, v5;
  logic [47:0]  b_res, s_res, u_res;
  logic [191:0] side1, side4, side5;
  logic [143:0] side2, side3;
  logic [146:0] c1;
  logic [98:0]  c2;

  logic         out_v_q;
  logic [239:0] out_q;
  logic [95:0]  shift_d;

  assign en = !v5 || !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i*33 +: 33] <= {s_axis_tdata_i[i*32+31], s_axis_tdata_i[i*32 +: 32]}
                         - {s_axis_tdata_i[96+i*32+31], s_axis_tdata_i[96+i*32 +: 32]};
      end
      side0_q <= {s_axis_tdata_i[95:0], s_axis_tdata_i[287:192]};
    end
  end

  lav_norm #(.IW(33), .SW(192)) u_norm_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .vec_i(d_q), .side_i(side0_q),
    .valid_o(v1), .res_o(b_res), .side_o(side1)
  );

  lav_cross #(.AW(32), .BW(ResW), .SW(144)) u_cross_side (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .a_i(side1[95:0]), .b_i(b_res),
    .side_i({side1[191:96], b_res}), .valid_o(v2), .c_o(c1), .side_o(side2)
  );

  lav_norm #(.IW(49), .SW(144)) u_norm_side (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .vec_i(c1), .side_i(side2),
    .valid_o(v3), .res_o(s_res), .side_o(side3)
  );

  lav_cross #(.AW(ResW), .BW(ResW), .SW(192)) u_cross_up (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3), .a_i(side3[47:0]), .b_i(s_res),
    .side_i({side3, s_res}), .valid_o(v4), .c_o(c2), .side_o(side4)
  );

  lav_norm #(.IW(33), .SW(192)) u_norm_up (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4), .vec_i(c2), .side_i(side4),
    .valid_o(v5), .res_o(u_res), .side_o(side5)
  );

  // negated eye, most negative value saturates
  always_comb begin
    logic [31:0] e;
    for (int i = 0; i < 3; i++) begin
      e = side5[96 + i*32 +: 32];
      shift_d[i*32 +: 32] = (e == 32'h8000_0000) ? 32'h7fff_ffff : (~e + 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en && v5) out_v_q <= 1'b1;
    else if (m_axis_tready_i) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en && v5) out_q <= {shift_d, side5[95:48], u_res, side5[47:0]};
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;
endmodule
`default_nettype wire
